[rtl/thpf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package thpf_pkg;

   // Field widths fixed by the pixel and result formats.
   localparam int PIX_W     = 16;
   localparam int RUN_W     = 13;
   localparam int HIT_COL_W = 12;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   // Saturation value of the run width counter.
   localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

   // Reset values of the configuration registers.
   localparam logic signed [PIX_W-1:0] THRESHOLD_RESET = '0;
   localparam logic [RUN_W-1:0]        MIN_WIDTH_RESET = RUN_W'(1);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_MIN_WIDTH = 1'b1
   } csr_index_type;

   // One pixel item as held in the input register.
   typedef struct packed {
      logic signed [PIX_W-1:0] pixel_value;
      logic                    last_in_row;
   } pix_item_type;

endpackage : thpf_pkg

`default_nettype wire

[rtl/thpf_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module thpf_in_stage (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [thpf_pkg::PIX_W-1:0] req_pixel_value,
   input  wire logic                        req_last_in_row,
   input  wire logic                        take,
   output logic                             item_valid,
   output thpf_pkg::pix_item_type           item
);
   import thpf_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   pix_item_type item_ff;
   logic         accept;

   // The register takes a new item when it is empty or its item moves on.
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded only on acceptance and needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.pixel_value <= req_pixel_value;
         item_ff.last_in_row <= req_last_in_row;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule : thpf_in_stage

`default_nettype wire

[rtl/thpf_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module thpf_core #(
   parameter int MAX_COLS = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             item_valid,
   input  wire thpf_pkg::pix_item_type           item,
   output logic                                  take,
   input  wire logic                             csr_write,
   input  wire logic [thpf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [thpf_pkg::CSR_W-1:0]       csr_wdata,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_hit_valid,
   output logic [thpf_pkg::HIT_COL_W-1:0]        rsp_hit_column,
   output logic                                  rsp_row_end
);
   import thpf_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);

   // Configuration registers.
   logic signed [PIX_W-1:0] threshold_ff;
   logic [RUN_W-1:0]        min_width_ff;

   // Hit tracking state.
   logic                    in_hit_ff, in_hit_in;
   logic [RUN_W-1:0]        run_width_ff, run_width_in;
   logic signed [PIX_W-1:0] peak_value_ff, peak_value_in;
   logic [COL_W-1:0]        peak_column_ff, peak_column_in;
   logic [COL_W-1:0]        column_index_ff, column_index_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    hit_valid_ff;
   logic [HIT_COL_W-1:0]    hit_column_ff;
   logic                    row_end_ff;

   logic                    step;
   logic                    above;
   logic                    report;
   logic [COL_W+HIT_COL_W-1:0] peak_column_wide;
   logic [HIT_COL_W-1:0]    report_col;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         min_width_ff <= MIN_WIDTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD: threshold_ff <= $signed(csr_wdata[PIX_W-1:0]);
            CSR_MIN_WIDTH: min_width_ff <= csr_wdata[RUN_W-1:0];
            default:       ;
         endcase
      end
   end

   // A pixel is processed when the result register can take its outcome.
   assign take = !rsp_valid_ff || !rsp_stall;
   assign step = item_valid && take;

   assign above = item.pixel_value >= threshold_ff;

   // Peak column as reported, truncated or zero-extended to the column field.
   assign peak_column_wide = {{HIT_COL_W{1'b0}}, peak_column_ff};

   // Hit open, update and close for the pixel in the input register.
   always_comb begin
      in_hit_in       = in_hit_ff;
      run_width_in    = run_width_ff;
      peak_value_in   = peak_value_ff;
      peak_column_in  = peak_column_ff;
      column_index_in = column_index_ff;
      report          = 1'b0;
      report_col      = '0;

      if (in_hit_ff) begin
         if (above) begin
            if (item.pixel_value > peak_value_ff) begin
               peak_value_in  = item.pixel_value;
               peak_column_in = column_index_ff;
            end
            if (run_width_ff != RUN_MAX) begin
               run_width_in = run_width_ff + RUN_W'(1);
            end
         end else begin
            if (run_width_ff >= min_width_ff) begin
               report     = 1'b1;
               report_col = peak_column_wide[HIT_COL_W-1:0];
            end
            in_hit_in      = 1'b0;
            run_width_in   = '0;
            peak_value_in  = '0;
            peak_column_in = '0;
         end
      end else if (above) begin
         in_hit_in      = 1'b1;
         peak_value_in  = item.pixel_value;
         peak_column_in = column_index_ff;
         run_width_in   = RUN_W'(1);
      end

      // The column counter stops at the last column the row can have.
      if (column_index_ff != COL_LAST) begin
         column_index_in = column_index_ff + COL_W'(1);
      end

      // The last pixel of a row clears everything for the next row.
      if (item.last_in_row) begin
         in_hit_in       = 1'b0;
         run_width_in    = '0;
         peak_value_in   = '0;
         peak_column_in  = '0;
         column_index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_hit_ff       <= 1'b0;
         run_width_ff    <= '0;
         peak_value_ff   <= '0;
         peak_column_ff  <= '0;
         column_index_ff <= '0;
      end else if (step) begin
         in_hit_ff       <= in_hit_in;
         run_width_ff    <= run_width_in;
         peak_value_ff   <= peak_value_in;
         peak_column_ff  <= peak_column_in;
         column_index_ff <= column_index_in;
      end
   end

   // Result register: loaded when a pixel gives a result, emptied when taken.
   always_comb begin
      if (step && (report || item.last_in_row)) begin
         rsp_valid_in = 1'b1;
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && (report || item.last_in_row)) begin
         hit_valid_ff  <= report;
         hit_column_ff <= report_col;
         row_end_ff    <= item.last_in_row;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit_valid  = hit_valid_ff;
   assign rsp_hit_column = hit_column_ff;
   assign rsp_row_end    = row_end_ff;

endmodule : thpf_core

`default_nettype wire

[rtl/threshold_hit_peak_finder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Threshold peak hit finder for one image row. Pixels enter in column order,
// one item per clock unless a stalled result holds the flow: an input
// register feeds a single compare-and-update step whose outcome lands in a
// result register, so the sustained rate is one pixel per cycle while rsp_stall
// is low. A result is given when a hit closes wide enough (its first-maximum
// column) and for every pixel marked last in the row; a hit still open at the
// row's end is dropped. Columns count from zero and stop at MAX_COLS - 1; the
// reported column is its low 12 bits.
// Configuration (threshold, min_width) may be written only while idle.
module threshold_hit_peak_finder #(
   parameter int MAX_COLS = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [thpf_pkg::PIX_W-1:0]    req_pixel_value,
   input  wire logic                                 req_last_in_row,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_hit_valid,
   output logic [thpf_pkg::HIT_COL_W-1:0]            rsp_hit_column,
   output logic                                      rsp_row_end,
   input  wire logic                                 csr_write,
   input  wire logic [thpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [thpf_pkg::CSR_W-1:0]           csr_wdata
);
   import thpf_pkg::*;

   logic         take;
   logic         item_valid;
   pix_item_type item;

   // Input register.
   thpf_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .req_last_in_row (req_last_in_row),
      .take            (take),
      .item_valid      (item_valid),
      .item            (item)
   );

   // Hit tracking and result register.
   thpf_core #(
      .MAX_COLS (MAX_COLS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .take           (take),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit_valid  (rsp_hit_valid),
      .rsp_hit_column (rsp_hit_column),
      .rsp_row_end    (rsp_row_end)
   );

endmodule : threshold_hit_peak_finder

`default_nettype wire

[rtl/thpf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module thpf_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_stall,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire logic                                 rsp_hit_valid,
   input  wire logic [thpf_pkg::HIT_COL_W-1:0]       rsp_hit_column,
   input  wire logic                                 rsp_row_end
);
   import thpf_pkg::*;

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_valid)
         && $stable(rsp_hit_column) && $stable(rsp_row_end))
      else $error("stalled result changed");

   // Every result reports a hit, a row end, or both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_valid || rsp_row_end)
      else $error("empty result item");

   // A result without a hit carries column zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit_valid |-> rsp_hit_column == '0)
      else $error("column set without a hit");

   // A fresh result must follow an accepted pixel.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching pixel");

endmodule : thpf_checker

bind threshold_hit_peak_finder thpf_checker u_thpf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hit_valid  (rsp_hit_valid),
   .rsp_hit_column (rsp_hit_column),
   .rsp_row_end    (rsp_row_end)
);

`default_nettype wire
